// ===== rtl/ffpa_pkg.sv =====
// Shared types, constants and helper functions for the first-fit partition allocator.
// Used by ffpa_datapath, ffpa_ctrl and first_fit_partition_allocator.
// Depends on nothing else.
package ffpa_pkg;

  // Sizing of the managed memory and of the free-segment table
  localparam int MEMORY_WORDS    = 1024;
  localparam int PARTITION_WORDS = 64;
  localparam int TABLE_DEPTH     = 32;

  // Fixed field widths of the item and result ports
  localparam int ADDR_W   = 10;
  localparam int ASZ_W    = 11;
  localparam int STATUS_W = 2;

  // Partitions that are free after reset, capped at the table depth
  localparam int PARTS_RAW  = MEMORY_WORDS / PARTITION_WORDS;
  localparam int INIT_PARTS = (PARTS_RAW > TABLE_DEPTH) ? TABLE_DEPTH : PARTS_RAW;

  // Table index and entry count widths
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Segment length saturates at LEN_CAP
  localparam int LEN_CAP = 2 * MEMORY_WORDS - 1;
  localparam int LEN_W   = $clog2(2 * MEMORY_WORDS);

  // Largest segment end (start + length) that the update rules can produce
  localparam int ADDR_MAX = (2 ** ADDR_W) - 1;
  localparam int ASZ_MAX  = (2 ** ASZ_W) - 1;
  localparam int GROW_MAX = (LEN_CAP > ASZ_MAX) ? LEN_CAP : ASZ_MAX;
  localparam int END_RAW  = ADDR_MAX + GROW_MAX;
  localparam int END_MAX  = (MEMORY_WORDS > END_RAW) ? MEMORY_WORDS : END_RAW;
  localparam int START_W  = $clog2(END_MAX + 1);

  // Width that holds both a length and the block size
  localparam int OP_W = (LEN_W > ASZ_W) ? LEN_W : ASZ_W;

  // Operation codes of an item
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // One free-table entry
  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } entry_t;

  // Source of the data written into the table
  typedef enum logic [2:0] {
    W_SHIFT = 3'd0,  // entry just read, moved one place
    W_TRIM  = 3'd1,  // entry just read, front trimmed by one block
    W_PRED  = 3'd2,  // entry just read, grown at its end
    W_SUCC  = 3'd3,  // recorded successor, moved down and grown
    W_INS   = 3'd4   // new entry for the freed block
  } wsel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             load_item;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    wsel_t            wr_sel;
    logic             cap_grant;
    logic             cap_succ;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] rd_idx;
    logic             alloc_gt;
    logic             alloc_eq;
    logic             pred_hit;
    logic             succ_hit;
    logic             pos_hit;
  } sts_t;

  // Table contents right after reset
  function automatic entry_t init_entry(input logic [IDX_W-1:0] idx);
    entry_t e;
    e = '0;
    if (int'(idx) < INIT_PARTS) begin
      e.start = START_W'(int'(idx) * PARTITION_WORDS);
      e.len   = LEN_W'(PARTITION_WORDS);
    end
    return e;
  endfunction

  // Add one block to a length, saturating at LEN_CAP
  function automatic logic [LEN_W-1:0] grow(input logic [LEN_W-1:0] len,
                                            input logic [ASZ_W-1:0] asz);
    logic [OP_W:0] sum;
    sum = (OP_W + 1)'(len) + (OP_W + 1)'(asz);
    if (sum > (OP_W + 1)'(LEN_CAP)) begin
      return LEN_W'(LEN_CAP);
    end
    return LEN_W'(sum);
  endfunction

  // Length of a fresh entry, capped at LEN_CAP
  function automatic logic [LEN_W-1:0] cap_len(input logic [ASZ_W-1:0] asz);
    if (OP_W'(asz) > OP_W'(LEN_CAP)) begin
      return LEN_W'(LEN_CAP);
    end
    return LEN_W'(asz);
  endfunction

endpackage

// ===== rtl/first_fit_partition_allocator.sv =====
// Top level of the first-fit partition allocator: item and result channels,
// block size write port, output register. Depends on ffpa_pkg, ffpa_datapath
// and ffpa_ctrl.

// The block keeps an address-ordered table of free segments, reset to equal
// partitions, and serves one item at a time: an allocate takes a block of
// alloc_size words first-fit, a free returns one and merges or inserts it.
// Every item walks the table through its single read port, one entry per
// cycle. An allocate trims the first entry that is long enough, or removes
// an exact fit and moves the later entries down; a free merges the block
// with a neighbouring segment, finds the table full, or inserts it at the
// tail or at its position below the tail and moves the later entries up.
// An insert needs count below TABLE_DEPTH. While the output register stays
// stalled, a finished item waits in S_RESP. in_stall is low only while no
// item is in work;
// a result waits in the output register so the next item can start, and
// cfg_ready is always high, writes belong to idle periods.
module first_fit_partition_allocator import ffpa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // Item channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_func,
  input  logic [ADDR_W-1:0]   in_free_address,
  // Result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [ADDR_W-1:0]   out_granted_address,
  // Block size write port
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [ASZ_W-1:0]    cfg_alloc_size
);

  cmd_t              cmd;
  sts_t              sts;
  logic              ctrl_idle;
  logic              ctrl_resp;
  status_t           ctrl_status;
  logic [ADDR_W-1:0] dp_granted;
  logic              out_free;
  logic              out_load;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ADDR_W-1:0]   out_granted_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = !ctrl_idle;

  ffpa_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_alloc_size    (cfg_alloc_size),
    .item_func         (in_func),
    .item_free_address (in_free_address),
    .cmd               (cmd),
    .sts               (sts),
    .granted_address   (dp_granted)
  );

  ffpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd),
    .idle     (ctrl_idle),
    .resp     (ctrl_resp),
    .status   (ctrl_status)
  );

  // Output register: load a finished result when the slot is empty or draining
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = ctrl_resp && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r  <= ctrl_status;
      out_granted_r <= dp_granted;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_address = out_granted_r;

  // A table write never lands on the entry being read in the same cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en && cmd.rd_en |-> cmd.wr_addr != cmd.rd_addr)
    else $error("table write and read collide on one entry");

  // A granted address is captured only while serving an allocate
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_grant |-> sts.func == FUNC_ALLOC)
    else $error("granted address captured on a free");

  // Only a successful result carries a nonzero granted address
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK) || (out_granted_address == '0))
    else $error("granted address nonzero on a failed result");

endmodule

// ===== rtl/ffpa_datapath.sv =====
// Datapath of the first-fit partition allocator: free-segment table, block size
// register, item registers, entry compare logic and granted address.
// Depends on ffpa_pkg.
module ffpa_datapath import ffpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [ASZ_W-1:0]  cfg_alloc_size,
  input  logic              item_func,
  input  logic [ADDR_W-1:0] item_free_address,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic [ADDR_W-1:0] granted_address
);

  entry_t                 mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld_r;
  entry_t                 rd_raw_r;
  logic                   rd_vld_r;
  logic [IDX_W-1:0]       rd_idx_r;
  logic [ASZ_W-1:0]       alloc_size_r;
  logic                   func_r;
  logic [ADDR_W-1:0]      addr_r;
  logic [LEN_W-1:0]       succ_len_r;
  logic [ADDR_W-1:0]      granted_r;

  entry_t             rdata;
  entry_t             wdata;
  logic [START_W-1:0] addr_ext;
  logic [START_W-1:0] asz_ext;
  logic [START_W-1:0] seg_end;
  logic [START_W-1:0] blk_end;

  // Table storage: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rd_raw_r <= mem[cmd.rd_addr];
    end
  end

  // Track written entries; an unwritten entry reads as its reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      rd_idx_r <= '0;
    end else begin
      if (cmd.wr_en) begin
        vld_r[cmd.wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_vld_r <= vld_r[cmd.rd_addr];
        rd_idx_r <= cmd.rd_addr;
      end
    end
  end

  assign rdata = rd_vld_r ? rd_raw_r : init_entry(rd_idx_r);

  // Block size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_size_r <= ASZ_W'(32);
    end else if (cfg_we) begin
      alloc_size_r <= cfg_alloc_size;
    end
  end

  // Hold the item, the recorded successor length and the granted address
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r    <= item_func;
      addr_r    <= item_free_address;
      granted_r <= '0;
    end else if (cmd.cap_grant) begin
      granted_r <= rdata.start[ADDR_W-1:0];
    end
    if (cmd.cap_succ) begin
      succ_len_r <= rdata.len;
    end
  end

  // Compare the entry just read against the item
  assign addr_ext = START_W'(addr_r);
  assign asz_ext  = START_W'(alloc_size_r);
  assign seg_end  = rdata.start + START_W'(rdata.len);
  assign blk_end  = addr_ext + asz_ext;

  always_comb begin
    sts          = '0;
    sts.func     = func_r;
    sts.rd_idx   = rd_idx_r;
    sts.alloc_gt = OP_W'(rdata.len) > OP_W'(alloc_size_r);
    sts.alloc_eq = OP_W'(rdata.len) == OP_W'(alloc_size_r);
    sts.pred_hit = (addr_ext > rdata.start) && (seg_end == addr_ext);
    sts.succ_hit = (addr_ext < rdata.start) && (blk_end == rdata.start);
    sts.pos_hit  = rdata.start >= addr_ext;
  end

  // Select write data
  always_comb begin
    wdata = rdata;
    unique case (cmd.wr_sel)
      W_SHIFT: wdata = rdata;
      W_TRIM: begin
        wdata.start = rdata.start + asz_ext;
        wdata.len   = rdata.len - LEN_W'(alloc_size_r);
      end
      W_PRED: begin
        wdata.start = rdata.start;
        wdata.len   = grow(rdata.len, alloc_size_r);
      end
      W_SUCC: begin
        wdata.start = addr_ext;
        wdata.len   = grow(succ_len_r, alloc_size_r);
      end
      W_INS: begin
        wdata.start = addr_ext;
        wdata.len   = cap_len(alloc_size_r);
      end
      default: wdata = rdata;
    endcase
  end

  assign granted_address = granted_r;

endmodule

// ===== rtl/ffpa_ctrl.sv =====
// Controller of the first-fit partition allocator: scans the table, shifts
// entries on erase and insert, keeps the entry count and the result status.
// Depends on ffpa_pkg.
module ffpa_ctrl import ffpa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    out_free,
  input  sts_t    sts,
  output cmd_t    cmd,
  output logic    idle,
  output logic    resp,
  output status_t status
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_ERASE  = 5'b00100,
    S_INSERT = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             pv_r, pv_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic             pos_found_r, pos_found_nxt;
  logic             succ_found_r, succ_found_nxt;
  logic [IDX_W-1:0] succ_idx_r, succ_idx_nxt;
  status_t          status_r, status_nxt;

  logic [CNT_W-1:0] idx_dec;
  logic [IDX_W-1:0] j;
  logic             scan_issue;
  logic             erase_issue;
  logic             ins_issue;

  assign idx_dec     = idx_r - 1'b1;
  assign j           = sts.rd_idx;
  assign scan_issue  = idx_r < count_r;
  assign erase_issue = idx_r < count_r;
  assign ins_issue   = idx_r > pos_r;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    pv_nxt         = pv_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    pos_found_nxt  = pos_found_r;
    succ_found_nxt = succ_found_r;
    succ_idx_nxt   = succ_idx_r;
    status_nxt     = status_r;
    cmd            = '0;
    cmd.rd_addr    = idx_r[IDX_W-1:0];
    cmd.wr_sel     = W_SHIFT;

    unique case (state_r)
      // Take an item and start the scan at entry zero
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item  = 1'b1;
          idx_nxt        = '0;
          pv_nxt         = 1'b0;
          pos_found_nxt  = 1'b0;
          succ_found_nxt = 1'b0;
          state_nxt      = S_SCAN;
        end
      end

      // Read one entry a cycle and judge the one read the cycle before
      S_SCAN: begin
        cmd.rd_en = scan_issue;
        if (pv_r && sts.func == FUNC_ALLOC && sts.alloc_gt) begin
          cmd.wr_en     = 1'b1;
          cmd.wr_addr   = j;
          cmd.wr_sel    = W_TRIM;
          cmd.cap_grant = 1'b1;
          status_nxt    = ST_OK;
          state_nxt     = S_RESP;
        end else if (pv_r && sts.func == FUNC_ALLOC && sts.alloc_eq) begin
          cmd.cap_grant = 1'b1;
          idx_nxt       = CNT_W'(j) + CNT_W'(1);
          pv_nxt        = 1'b0;
          state_nxt     = S_ERASE;
        end else if (pv_r && sts.func == FUNC_FREE && sts.pred_hit) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = j;
          cmd.wr_sel  = W_PRED;
          status_nxt  = ST_OK;
          state_nxt   = S_RESP;
        end else begin
          // Record the first successor and the first insert position
          if (pv_r && sts.func == FUNC_FREE) begin
            if (sts.succ_hit && !succ_found_r) begin
              succ_found_nxt = 1'b1;
              succ_idx_nxt   = j;
              cmd.cap_succ   = 1'b1;
            end
            if (sts.pos_hit && !pos_found_r) begin
              pos_found_nxt = 1'b1;
              pos_nxt       = CNT_W'(j);
            end
          end
          if (scan_issue) begin
            idx_nxt = idx_r + 1'b1;
            pv_nxt  = 1'b1;
          end else begin
            pv_nxt = 1'b0;
          end
          // Whole table seen: decide the outcome
          if (!scan_issue && !pv_r) begin
            if (sts.func == FUNC_ALLOC) begin
              status_nxt = ST_NOSPACE;
              state_nxt  = S_RESP;
            end else if (succ_found_r) begin
              cmd.wr_en   = 1'b1;
              cmd.wr_addr = succ_idx_r;
              cmd.wr_sel  = W_SUCC;
              status_nxt  = ST_OK;
              state_nxt   = S_RESP;
            end else if (count_r == CNT_W'(TABLE_DEPTH)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_RESP;
            end else begin
              pos_nxt   = pos_found_r ? pos_r : count_r;
              idx_nxt   = count_r;
              state_nxt = S_INSERT;
            end
          end
        end
      end

      // Move the entries after an exact fit down by one place
      S_ERASE: begin
        cmd.rd_en = erase_issue;
        if (pv_r) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = j - IDX_W'(1);
          cmd.wr_sel  = W_SHIFT;
        end
        if (erase_issue) begin
          idx_nxt = idx_r + 1'b1;
          pv_nxt  = 1'b1;
        end else begin
          pv_nxt = 1'b0;
        end
        if (!erase_issue && !pv_r) begin
          count_nxt  = count_r - 1'b1;
          status_nxt = ST_OK;
          state_nxt  = S_RESP;
        end
      end

      // Move the entries from the insert position up by one, then write the block
      S_INSERT: begin
        cmd.rd_en   = ins_issue;
        cmd.rd_addr = idx_dec[IDX_W-1:0];
        if (pv_r) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = j + IDX_W'(1);
          cmd.wr_sel  = W_SHIFT;
        end
        if (ins_issue) begin
          idx_nxt = idx_dec;
          pv_nxt  = 1'b1;
        end else begin
          pv_nxt = 1'b0;
        end
        if (!ins_issue && !pv_r) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = pos_r[IDX_W-1:0];
          cmd.wr_sel  = W_INS;
          count_nxt   = count_r + 1'b1;
          status_nxt  = ST_OK;
          state_nxt   = S_RESP;
        end
      end

      // Hand the result over once the output register can take it
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      pv_r         <= 1'b0;
      count_r      <= CNT_W'(INIT_PARTS);
      pos_r        <= '0;
      pos_found_r  <= 1'b0;
      succ_found_r <= 1'b0;
      succ_idx_r   <= '0;
      status_r     <= ST_OK;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      pv_r         <= pv_nxt;
      count_r      <= count_nxt;
      pos_r        <= pos_nxt;
      pos_found_r  <= pos_found_nxt;
      succ_found_r <= succ_found_nxt;
      succ_idx_r   <= succ_idx_nxt;
      status_r     <= status_nxt;
    end
  end

  assign idle   = state_r == S_IDLE;
  assign resp   = state_r == S_RESP;
  assign status = status_r;

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for first_fit_partition_allocator: directed and random allocate
// and free items, each result checked against a local model of the free-segment table or a typed-in value.
// Depends on ffpa_pkg and the allocator RTL.
module testbench import ffpa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_BLOCK_WORDS = 32;
  localparam int PHASES            = 10;
  localparam int PHASE_ITEMS       = 150;
  localparam int HOLD_OFF_AT       = 300;
  localparam int HOLD_OFF_CYCLES   = 400;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_func;
  logic [ADDR_W-1:0]   in_free_address;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [ADDR_W-1:0]   out_granted_address;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [ASZ_W-1:0]    cfg_alloc_size;

  typedef struct {
    status_t           status;
    logic [ADDR_W-1:0] granted;
  } response_t;

  typedef enum {STEP_ITEM, STEP_SIZE} step_kind_t;

  typedef struct {
    step_kind_t        kind;
    logic              func;
    logic [ADDR_W-1:0] addr;
    logic [ASZ_W-1:0]  words;
    bit                typed;
    status_t           status;
    logic [ADDR_W-1:0] granted;
  } step_t;

  // Local copy of the free-segment table and the block size
  logic [START_W-1:0] free_base [TABLE_DEPTH];
  logic [LEN_W-1:0]   free_words [TABLE_DEPTH];
  int unsigned        free_entries;
  logic [ASZ_W-1:0]   block_words;

  response_t         pending_results[$];
  int                results_owed = 0;
  logic [ADDR_W-1:0] granted_blocks[$];
  int                error_count = 0;
  bit                quiet_mode = 1'b0;

  // Directed steps; expected values typed in only where they are obvious
  step_t directed_steps [22] = '{
    // first fit after reset: trim the first partition, then take its exact rest
    '{STEP_ITEM, FUNC_ALLOC, 10'd1023, 11'd0, 1'b1, ST_OK, 10'd0},
    '{STEP_ITEM, FUNC_ALLOC, 10'd0, 11'd0, 1'b1, ST_OK, 10'd32},
    // merge with the following segment, twice
    '{STEP_ITEM, FUNC_FREE, 10'd32, 11'd0, 1'b0, ST_OK, 10'd0},
    '{STEP_ITEM, FUNC_FREE, 10'd0, 11'd0, 1'b0, ST_OK, 10'd0},
    // insert at the tail, highest address, then a double free
    '{STEP_ITEM, FUNC_FREE, 10'd1000, 11'd0, 1'b0, ST_OK, 10'd0},
    '{STEP_ITEM, FUNC_FREE, 10'd1023, 11'd0, 1'b0, ST_OK, 10'd0},
    '{STEP_ITEM, FUNC_FREE, 10'd1000, 11'd0, 1'b0, ST_OK, 10'd0},
    // largest block size: no room, then a saturating merge makes one
    '{STEP_SIZE, FUNC_ALLOC, 10'd0, 11'd2047, 1'b0, ST_OK, 10'd0},
    '{STEP_ITEM, FUNC_ALLOC, 10'd512, 11'd0, 1'b1, ST_NOSPACE, 10'd0},
    '{STEP_ITEM, FUNC_FREE, 10'd128, 11'd0, 1'b0, ST_OK, 10'd0},
    '{STEP_ITEM, FUNC_ALLOC, 10'd0, 11'd0, 1'b1, ST_OK, 10'd0},
    // zero block size: a zero-length entry is removed, a longer one stays
    '{STEP_SIZE, FUNC_ALLOC, 10'd0, 11'd0, 1'b0, ST_OK, 10'd0},
    '{STEP_ITEM, FUNC_FREE, 10'd0, 11'd0, 1'b0, ST_OK, 10'd0},
    '{STEP_ITEM, FUNC_ALLOC, 10'd0, 11'd0, 1'b1, ST_OK, 10'd0},
    '{STEP_ITEM, FUNC_ALLOC, 10'd0, 11'd0, 1'b1, ST_OK, 10'd128},
    '{STEP_ITEM, FUNC_FREE, 10'd500, 11'd0, 1'b0, ST_OK, 10'd0},
    // smallest block size
    '{STEP_SIZE, FUNC_ALLOC, 10'd0, 11'd1, 1'b0, ST_OK, 10'd0},
    '{STEP_ITEM, FUNC_ALLOC, 10'd0, 11'd0, 1'b1, ST_OK, 10'd128},
    // full memory size: no room, insert a whole-memory block, take it back
    '{STEP_SIZE, FUNC_ALLOC, 10'd0, 11'd1024, 1'b0, ST_OK, 10'd0},
    '{STEP_ITEM, FUNC_ALLOC, 10'd0, 11'd0, 1'b1, ST_NOSPACE, 10'd0},
    '{STEP_ITEM, FUNC_FREE, 10'd0, 11'd0, 1'b0, ST_OK, 10'd0},
    '{STEP_ITEM, FUNC_ALLOC, 10'd0, 11'd0, 1'b1, ST_OK, 10'd0}
  };

  first_fit_partition_allocator DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_free_address     (in_free_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_granted_address (out_granted_address),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_alloc_size      (cfg_alloc_size)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Clamp a segment length at its cap
  function automatic logic [LEN_W-1:0] saturate_len(input int unsigned words);
    return (words > LEN_CAP) ? LEN_W'(LEN_CAP) : LEN_W'(words);
  endfunction

  // Mostly short idle gaps, a few long ones, none in quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  // Apply one request to the local table and return the allocator's answer
  function automatic response_t serve_request(input logic func,
                                              input logic [ADDR_W-1:0] addr);
    response_t   rsp;
    int unsigned a;
    int unsigned pos;
    bit          done;
    rsp.status  = ST_OK;
    rsp.granted = '0;
    a           = addr;
    done        = 1'b0;
    if (func == FUNC_ALLOC) begin
      rsp.status = ST_NOSPACE;
      // take the first segment that is long enough
      for (int i = 0; i < free_entries && !done; i++) begin
        if (free_words[i] >= block_words) begin
          done        = 1'b1;
          rsp.status  = ST_OK;
          rsp.granted = free_base[i][ADDR_W-1:0];
          if (free_words[i] > block_words) begin
            free_base[i]  = free_base[i] + block_words;
            free_words[i] = free_words[i] - block_words;
          end else begin
            // exact fit: drop the entry and close the hole
            for (int k = i; k + 1 < free_entries; k++) begin
              free_base[k]  = free_base[k+1];
              free_words[k] = free_words[k+1];
            end
            free_entries--;
            free_base[free_entries]  = '0;
            free_words[free_entries] = '0;
          end
        end
      end
    end else begin
      // grow a segment that ends at the block
      for (int i = 0; i < free_entries && !done; i++) begin
        if (a > free_base[i] && int'(free_base[i]) + int'(free_words[i]) == a) begin
          free_words[i] = saturate_len(int'(free_words[i]) + int'(block_words));
          done          = 1'b1;
        end
      end
      // otherwise pull down a segment that starts at the block's end
      for (int i = 0; i < free_entries && !done; i++) begin
        if (a < free_base[i] && a + block_words == free_base[i]) begin
          free_base[i]  = START_W'(a);
          free_words[i] = saturate_len(int'(free_words[i]) + int'(block_words));
          done          = 1'b1;
        end
      end
      // otherwise insert in address order, unless the table is full
      if (!done) begin
        if (free_entries >= TABLE_DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          pos = free_entries;
          for (int i = int'(free_entries) - 1; i >= 0; i--) begin
            if (free_base[i] >= a) pos = i;
          end
          for (int k = free_entries; k > pos; k--) begin
            free_base[k]  = free_base[k-1];
            free_words[k] = free_words[k-1];
          end
          free_base[pos]  = START_W'(a);
          free_words[pos] = saturate_len(block_words);
          free_entries++;
        end
      end
    end
    return rsp;
  endfunction

  // Queue the predicted result of an accepted item
  task automatic expect_result(input response_t rsp);
    pending_results.insert(pending_results.size(), rsp);
    results_owed++;
  endtask

  // Offer one item after a random gap, hold it until taken, predict its result
  task automatic send_request(input logic func, input logic [ADDR_W-1:0] addr,
                              output response_t rsp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= func;
    in_free_address <= addr;
    do @(posedge clk); while (in_stall);
    rsp = serve_request(func, addr);
  endtask

  // Write the block size once the block has drained
  task automatic write_block_size(input logic [ASZ_W-1:0] words);
    in_valid <= 1'b0;
    wait (results_owed == 0);
    cfg_alloc_size <= words;
    cfg_valid      <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    block_words = words;
  endtask

  // Take results under random stall and compare with the oldest prediction
  initial begin : result_check
    int        stall_left;
    int        results_seen;
    bit        held_off;
    response_t want;
    stall_left   = 0;
    results_seen = 0;
    held_off     = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result with no item pending: status %0d, granted_address %0d",
                 out_status, out_granted_address);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          results_owed--;
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            error_count++;
          end
          if (out_granted_address !== want.granted) begin
            $error("granted_address: expected %0d, got %0d", want.granted,
                   out_granted_address);
            error_count++;
          end
        end
      end
      // hold off once for a long stretch so the block backs up into its input
      if (!held_off && results_seen == HOLD_OFF_AT) begin
        held_off   = 1'b1;
        stall_left = HOLD_OFF_CYCLES;
      end else if (stall_left == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    response_t         rsp;
    int unsigned       parts;
    int                r;
    int                k;
    logic [ADDR_W-1:0] addr;
    logic [ASZ_W-1:0]  phase_words [PHASES];
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_func         <= FUNC_ALLOC;
    in_free_address <= '0;
    cfg_valid       <= 1'b0;
    cfg_alloc_size  <= '0;

    // table after reset: equal partitions, capped at the table depth
    parts = MEMORY_WORDS / PARTITION_WORDS;
    if (parts > TABLE_DEPTH) parts = TABLE_DEPTH;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      free_base[i]  = (i < parts) ? START_W'(i * PARTITION_WORDS) : '0;
      free_words[i] = (i < parts) ? LEN_W'(PARTITION_WORDS) : '0;
    end
    free_entries = parts;
    block_words  = ASZ_W'(RESET_BLOCK_WORDS);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed steps
    foreach (directed_steps[n]) begin
      if (directed_steps[n].kind == STEP_SIZE) begin
        write_block_size(directed_steps[n].words);
      end else begin
        send_request(directed_steps[n].func, directed_steps[n].addr, rsp);
        if (directed_steps[n].typed) begin
          rsp.status  = directed_steps[n].status;
          rsp.granted = directed_steps[n].granted;
        end
        expect_result(rsp);
      end
    end

    // random phases, each under its own block size
    phase_words = '{11'd32, 11'd1, 11'd64, 11'd5, 11'd0, 11'd1024, 11'd2047,
                    11'd16, 11'd1, 11'd48};
    phase_words[7] = ASZ_W'($urandom_range(2, 1023));
    for (int p = 0; p < PHASES; p++) begin
      write_block_size(phase_words[p]);
      quiet_mode = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // pause the sender once mid-phase until the block has drained
        if (p == 3 && n == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          wait (results_owed == 0);
        end
        r    = $urandom_range(0, 99);
        addr = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
        if (r < 45) begin
          send_request(FUNC_ALLOC, addr, rsp);
          if (rsp.status == ST_OK) begin
            granted_blocks.insert(granted_blocks.size(), rsp.granted);
          end
        end else begin
          // mostly return a granted block, else free a random address
          if (r < 85 && granted_blocks.size() > 0) begin
            k    = $urandom_range(0, granted_blocks.size() - 1);
            addr = granted_blocks[k];
            granted_blocks.delete(k);
          end
          send_request(FUNC_FREE, addr, rsp);
        end
        expect_result(rsp);
      end
    end

    // drain, then give any stray result time to show up
    in_valid <= 1'b0;
    wait (results_owed == 0);
    repeat (2 * TABLE_DEPTH + 16) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #3_500_000;
    $display("FAIL");
    $finish;
  end

endmodule
